>>> rtl/core/ehbs_pkg.sv
package ehbs_pkg;

    // Store geometry and CORDIC length
    localparam int MAX_COLS     = 512;
    localparam int MAX_ROWS     = 256;
    localparam int CORDIC_STEPS = 16;
    localparam int CS_N         = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int WE_W        = $clog2(MAX_COLS + 1);
    localparam int HE_W        = $clog2(MAX_ROWS + 1);
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Datapath widths
    localparam int CW       = 28;             // CORDIC x/y
    localparam int ZW       = 34;             // CORDIC angle, 2^-32 turn
    localparam int SQ_STEPS = 24;             // root bits of a 48-bit radicand
    localparam int SQ_W     = 2 * SQ_STEPS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int PX_W     = 16 + WE_W;
    localparam int PY_W     = 17 + HE_W;
    localparam int LVL_W    = 24;
    localparam int S_W      = 41;
    localparam int SH_W     = S_W - 24;
    localparam int PA_W     = 42;
    localparam int PB_W     = 35;
    localparam int TS_W     = PB_W + 24;
    localparam int T_W      = 25;
    localparam int P_W      = 43;
    localparam int B_W      = P_W - 16;
    localparam int Q_W      = B_W + 1 - 8;

    localparam logic signed [ZW+1:0] HALF_TURN  = {{(ZW - 30){1'b0}}, 32'h8000_0000};
    localparam logic [P_W-1:0]       ROUND_HALF = P_W'(23'd8355840);
    localparam logic [15:0]          LUMA_R     = 16'd19595;
    localparam logic [15:0]          LUMA_G     = 16'd38470;
    localparam logic [15:0]          LUMA_B     = 16'd7471;

    // Pipeline stage positions
    localparam int ST_IN   = 0;
    localparam int ST_SQ   = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_LON0 = 2;
    localparam int ST_SQ0  = 3;
    localparam int ST_LAT  = ST_SQ0 + SQ_STEPS;
    localparam int ST_LAT0 = ST_LAT + 1;
    localparam int ST_V    = ST_LAT0 + CS_N;
    localparam int ST_PIX  = ST_V + 1;
    localparam int ST_ADR  = ST_PIX + 1;
    localparam int ST_MEM  = ST_ADR + 1;
    localparam int ST_LVL  = ST_MEM + 1;
    localparam int ST_S01  = ST_LVL + 1;
    localparam int ST_PP   = ST_S01 + 1;
    localparam int ST_T    = ST_PP + 1;
    localparam int ST_PROD = ST_T + 1;
    localparam int ST_ABS  = ST_PROD + 1;
    localparam int ST_QE   = ST_ABS + 1;
    localparam int ST_H    = ST_QE + 1;
    localparam int N_ST    = ST_H + 1;

    // Register indexes
    localparam int              CFG_IDX_W     = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREY      = 3'd4;

    // Request kinds
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [8:0]         pixel_col;
        logic [7:0]         pixel_row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] height_out;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
    } out_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

    typedef struct packed {
        logic                     vld;
        logic                     act;
        logic [8:0]               col;
        logic [7:0]               row;
        logic [23:0]              rgb;
        logic signed [15:0]       nx;
        logic signed [15:0]       ny;
        logic signed [15:0]       nz;
        logic [30:0]              sqx;
        logic [30:0]              sqz;
        logic [SQ_W-1:0]          sv;
        logic [SQ_W-1:0]          sr;
        cordic_t                  lon;
        cordic_t                  lat;
        logic [15:0]              u16;
        logic [15:0]              v16;
        logic [PX_W-1:0]          px;
        logic [PY_W-1:0]          py;
        logic [COL_W-1:0]         x0;
        logic [COL_W-1:0]         x1;
        logic [ROW_W-1:0]         y0;
        logic [ROW_W-1:0]         y1;
        logic [15:0]              fx;
        logic [15:0]              fy;
        logic                     loaded;
        logic [3:0][LVL_W-1:0]    lv;
        logic [S_W-1:0]           s0;
        logic [S_W-1:0]           s1;
        logic [PA_W-1:0]          pa;
        logic [PB_W-1:0]          pb;
        logic [T_W-1:0]           t;
        logic signed [P_W-1:0]    prod;
        logic                     neg;
        logic [B_W-1:0]           b;
        logic [Q_W-1:0]           qe;
        logic signed [15:0]       hval;
    } pipe_t;

    function automatic logic [29:0] atan_turn(int i);
        logic [29:0] a;
        case (i)
            0:       a = 30'd536870912;
            1:       a = 30'd316933406;
            2:       a = 30'd167458907;
            3:       a = 30'd85004756;
            4:       a = 30'd42667331;
            5:       a = 30'd21354465;
            6:       a = 30'd10679838;
            7:       a = 30'd5340245;
            8:       a = 30'd2670163;
            9:       a = 30'd1335087;
            10:      a = 30'd667544;
            11:      a = 30'd333772;
            12:      a = 30'd166886;
            13:      a = 30'd83443;
            14:      a = 30'd41722;
            15:      a = 30'd20861;
            16:      a = 30'd10430;
            17:      a = 30'd5215;
            18:      a = 30'd2608;
            19:      a = 30'd1304;
            20:      a = 30'd652;
            21:      a = 30'd326;
            22:      a = 30'd163;
            23:      a = 30'd81;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

    // One vectoring micro-rotation; i is a constant at each call site
    function automatic cordic_t cordic_step(cordic_t c, int i);
        cordic_t              r;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] zs;
        logic signed [ZW-1:0] da;
        xs = c.x;
        ys = c.y;
        zs = c.z;
        dx = ys >>> i;
        dy = xs >>> i;
        da = $signed(ZW'(atan_turn(i)));
        r  = c;
        if (ys > 0) begin
            r.x = xs + dx;
            r.y = ys - dy;
            r.z = zs + da;
        end else begin
            r.x = xs - dx;
            r.y = ys + dy;
            r.z = zs - da;
        end
        return r;
    endfunction

    // Turn offset angle into Q0.16, saturating at both ends
    function automatic logic [15:0] to_q16(logic signed [ZW+1:0] a);
        logic [15:0] q;
        if (a[ZW+1]) begin
            q = 16'h0000;
        end else if (a[ZW:32] != '0) begin
            q = 16'hFFFF;
        end else begin
            q = a[31:16];
        end
        return q;
    endfunction

    function automatic logic [LVL_W-1:0] level_of(logic [23:0] rgb, logic grey);
        logic [LVL_W-1:0] l;
        if (grey) begin
            l = {rgb[23:16], 16'h0000};
        end else begin
            l = LVL_W'(rgb[23:16]) * LVL_W'(LUMA_R)
              + LVL_W'(rgb[15:8])  * LVL_W'(LUMA_G)
              + LVL_W'(rgb[7:0])   * LVL_W'(LUMA_B);
        end
        return l;
    endfunction

endpackage

>>> rtl/core/equirect_heightmap_bilinear_sampler.sv
// Channel   Ports                          Direction  Moves
// s_        s_valid s_ready s_data         in         pixel write or sample request
// m_        m_valid m_ready m_data         out        height and texture coordinates
// cfg_      cfg_valid cfg_ready cfg_index  in         register write (cfg_data)
//
// One request enters per cycle while the pipeline is not held; a sample result passes
// through the 24-step square-root chain plus the 16-step latitude CORDIC.
// A pixel write commits to the store at the address stage and produces no result.
// Reset (aresetn low, synchronous) empties the pipeline, clears the loaded flag and
// restores the register defaults; the pixel store is not cleared.
// The whole pipeline holds while a result waits on m_ready; nothing is lost or repeated.
module equirect_heightmap_bilinear_sampler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  ehbs_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output ehbs_pkg::out_t                 m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ehbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import ehbs_pkg::*;

    // Configuration registers
    logic signed [15:0] min_reg;
    logic signed [15:0] max_reg;
    logic [9:0]         width_reg;
    logic [8:0]         height_reg;
    logic               grey_reg;
    logic               loaded_reg;

    // Effective image size: zero counts as one, oversize clamps to the store
    logic [WE_W-1:0] w_eff;
    logic [HE_W-1:0] h_eff;

    logic adv;

    pipe_t       st_reg [N_ST];
    logic [23:0] rd_reg [4];

    // Store ports, driven from the address stage
    logic [ADDR_W-1:0] rd_addr [4];
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg    <= 16'sd0;
            max_reg    <= 16'sd256;
            width_reg  <= 10'd512;
            height_reg <= 9'd256;
            grey_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_LEVEL: min_reg    <= cfg_data;
                CFG_MAX_LEVEL: max_reg    <= cfg_data;
                CFG_WIDTH:     width_reg  <= cfg_data[9:0];
                CFG_HEIGHT:    height_reg <= cfg_data[8:0];
                CFG_GREY:      grey_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            w_eff = WE_W'(1);
        end else if (32'(width_reg) > MAX_COLS) begin
            w_eff = WE_W'(MAX_COLS);
        end else begin
            w_eff = WE_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HE_W'(1);
        end else if (32'(height_reg) > MAX_ROWS) begin
            h_eff = HE_W'(MAX_ROWS);
        end else begin
            h_eff = HE_W'(height_reg);
        end
    end

    // Global advance: freeze everything only when a result is stuck at the output
    assign m_valid = st_reg[ST_H].vld && (st_reg[ST_H].act == ACT_SAMPLE);
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    assign m_data.height_out = st_reg[ST_H].hval;
    assign m_data.tex_u      = st_reg[ST_H].u16;
    assign m_data.tex_v      = st_reg[ST_H].v16;

    // Pipeline stages
    for (genvar j = 0; j < N_ST; j++) begin : g_st
        pipe_t nxt;

        if (j == ST_IN) begin : g_in
            always_comb begin
                nxt       = '0;
                nxt.vld   = s_valid;
                nxt.act   = s_data.action;
                nxt.col   = s_data.pixel_col;
                nxt.row   = s_data.pixel_row;
                nxt.rgb   = {s_data.red, s_data.green, s_data.blue};
                nxt.nx    = s_data.normal_x;
                nxt.nz    = s_data.normal_z;
                // clamp y to plus or minus one
                if (s_data.normal_y > 16'sd16384) begin
                    nxt.ny = 16'sd16384;
                end else if (s_data.normal_y < -16'sd16384) begin
                    nxt.ny = -16'sd16384;
                end else begin
                    nxt.ny = s_data.normal_y;
                end
            end
        end else begin : g_work
            localparam int LI  = (j >= ST_LON0) ? j - ST_LON0 : 0;
            localparam int SI  = (j >= ST_SQ0)  ? j - ST_SQ0  : 0;
            localparam int AI  = (j >= ST_LAT0) ? j - ST_LAT0 : 0;
            localparam int SQB = (SI < SQ_STEPS) ? 2 * (SQ_STEPS - 1 - SI) : 0;

            always_comb begin
                logic signed [CW-1:0]   xi;
                logic signed [CW-1:0]   yi;
                logic signed [ZW-1:0]   ang;
                logic signed [ZW+1:0]   off;
                logic signed [31:0]     sq_x;
                logic signed [31:0]     sq_z;
                logic [SQ_W-1:0]        bitv;
                logic [SQ_W-1:0]        trial;
                logic [WE_W-1:0]        x0w;
                logic [WE_W-1:0]        x1w;
                logic [HE_W:0]          y0w;
                logic [HE_W:0]          y1w;
                logic [HE_W-1:0]        hm1;
                logic [16:0]            wa;
                logic [16:0]            wb;
                logic [TS_W-1:0]        ssum;
                logic signed [16:0]     diff;
                logic [P_W-1:0]         mag;
                logic [P_W-1:0]         rnd;
                logic [B_W:0]           est;
                logic [B_W-1:0]         rem;
                logic [Q_W-1:0]         q;

                nxt = st_reg[j-1];

                if (j == ST_SQ) begin
                    sq_x    = nxt.nx * nxt.nx;
                    sq_z    = nxt.nz * nxt.nz;
                    nxt.sqx = sq_x[30:0];
                    nxt.sqz = sq_z[30:0];
                    // longitude vector (x, z) scaled by 256, folded into the right half
                    xi = {{(CW - 24){nxt.nx[15]}}, nxt.nx, 8'h00};
                    yi = {{(CW - 24){nxt.nz[15]}}, nxt.nz, 8'h00};
                    nxt.lon.zero = (nxt.nx == 16'sd0) && (nxt.nz == 16'sd0);
                    if (xi < 0) begin
                        nxt.lon.z = (yi >= 0) ? ZW'(HALF_TURN) : -ZW'(HALF_TURN);
                        nxt.lon.x = -xi;
                        nxt.lon.y = -yi;
                    end else begin
                        nxt.lon.z = '0;
                        nxt.lon.x = xi;
                        nxt.lon.y = yi;
                    end
                end

                if (j == ST_SUM) begin
                    nxt.sv = {32'(nxt.sqx) + 32'(nxt.sqz), 16'h0000};
                    nxt.sr = '0;
                end

                if (j >= ST_LON0 && j < ST_LON0 + CS_N) begin
                    nxt.lon = cordic_step(nxt.lon, LI);
                end

                if (j >= ST_SQ0 && j < ST_SQ0 + SQ_STEPS) begin
                    bitv  = SQ_W'(1) << SQB;
                    trial = nxt.sr + bitv;
                    if (nxt.sv >= trial) begin
                        nxt.sv = nxt.sv - trial;
                        nxt.sr = (nxt.sr >> 1) + bitv;
                    end else begin
                        nxt.sr = nxt.sr >> 1;
                    end
                end

                if (j == ST_LAT) begin
                    ang     = nxt.lon.zero ? '0 : nxt.lon.z;
                    off     = (ZW + 2)'(ang) + HALF_TURN;
                    nxt.u16 = to_q16(off);
                    nxt.lat.x    = {{(CW - ROOT_W){1'b0}}, nxt.sr[ROOT_W-1:0]};
                    nxt.lat.y    = {{(CW - 24){nxt.ny[15]}}, nxt.ny, 8'h00};
                    nxt.lat.z    = '0;
                    nxt.lat.zero = (nxt.sr[ROOT_W-1:0] == '0) && (nxt.ny == 16'sd0);
                end

                if (j >= ST_LAT0 && j < ST_LAT0 + CS_N) begin
                    nxt.lat = cordic_step(nxt.lat, AI);
                end

                if (j == ST_V) begin
                    ang     = nxt.lat.zero ? '0 : nxt.lat.z;
                    off     = ((ZW + 2)'(ang) <<< 1) + HALF_TURN;
                    nxt.v16 = to_q16(off);
                end

                if (j == ST_PIX) begin
                    nxt.px = PX_W'(nxt.u16) * PX_W'(w_eff);
                    nxt.py = PY_W'(17'h10000 - 17'(nxt.v16)) * PY_W'(h_eff);
                end

                if (j == ST_ADR) begin
                    // wrap horizontally, clamp vertically
                    x0w = nxt.px[PX_W-1:16];
                    if (x0w >= w_eff) begin
                        x0w = w_eff - 1'b1;
                    end
                    x1w = WE_W'(x0w + 1'b1);
                    if (x1w >= w_eff) begin
                        x1w = '0;
                    end
                    hm1 = h_eff - 1'b1;
                    y0w = nxt.py[PY_W-1:16];
                    y1w = y0w + 1'b1;
                    if (y0w > (HE_W + 1)'(hm1)) begin
                        y0w = (HE_W + 1)'(hm1);
                    end
                    if (y1w > (HE_W + 1)'(hm1)) begin
                        y1w = (HE_W + 1)'(hm1);
                    end
                    nxt.x0 = COL_W'(x0w);
                    nxt.x1 = COL_W'(x1w);
                    nxt.y0 = ROW_W'(y0w);
                    nxt.y1 = ROW_W'(y1w);
                    nxt.fx = nxt.px[15:0];
                    nxt.fy = nxt.py[15:0];
                end

                if (j == ST_MEM) begin
                    nxt.loaded = loaded_reg;
                end

                if (j == ST_LVL) begin
                    for (int m = 0; m < 4; m++) begin
                        nxt.lv[m] = level_of(rd_reg[m], grey_reg);
                    end
                end

                if (j == ST_S01) begin
                    wa     = 17'h10000 - 17'(nxt.fx);
                    wb     = 17'(nxt.fx);
                    nxt.s0 = S_W'(nxt.lv[0]) * S_W'(wa) + S_W'(nxt.lv[1]) * S_W'(wb);
                    nxt.s1 = S_W'(nxt.lv[2]) * S_W'(wa) + S_W'(nxt.lv[3]) * S_W'(wb);
                end

                if (j == ST_PP) begin
                    // split the vertical blend into low and high partial products
                    wa     = 17'h10000 - 17'(nxt.fy);
                    wb     = 17'(nxt.fy);
                    nxt.pa = PA_W'(nxt.s0[23:0]) * PA_W'(wa)
                           + PA_W'(nxt.s1[23:0]) * PA_W'(wb);
                    nxt.pb = PB_W'(nxt.s0[S_W-1:24]) * PB_W'(wa)
                           + PB_W'(nxt.s1[S_W-1:24]) * PB_W'(wb);
                end

                if (j == ST_T) begin
                    ssum  = {nxt.pb, 24'h000000} + TS_W'(nxt.pa) + TS_W'(32'h8000_0000);
                    nxt.t = ssum[32+T_W-1:32];
                end

                if (j == ST_PROD) begin
                    diff     = 17'(max_reg) - 17'(min_reg);
                    nxt.prod = $signed({1'b0, nxt.t}) * diff;
                end

                if (j == ST_ABS) begin
                    nxt.neg = nxt.prod[P_W-1];
                    mag     = nxt.neg ? P_W'(-nxt.prod) : P_W'(nxt.prod);
                    rnd     = mag + ROUND_HALF;
                    nxt.b   = rnd[P_W-1:16];
                end

                if (j == ST_QE) begin
                    // b/255 from the series b/256 * (1 + 1/256 + ...), low by at most one
                    est    = (B_W + 1)'(nxt.b) + (B_W + 1)'(nxt.b >> 8)
                           + (B_W + 1)'(nxt.b >> 16) + (B_W + 1)'(nxt.b >> 24);
                    nxt.qe = est[B_W:8];
                end

                if (j == ST_H) begin
                    rem = nxt.b - (B_W'({nxt.qe, 8'h00}) - B_W'(nxt.qe));
                    q   = (rem >= B_W'(255)) ? Q_W'(nxt.qe + 1'b1) : nxt.qe;
                    if (nxt.loaded) begin
                        nxt.hval = min_reg + (nxt.neg ? -16'(q) : 16'(q));
                    end else begin
                        nxt.hval = 16'sd0;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[j].vld <= 1'b0;
            end else if (adv) begin
                st_reg[j] <= nxt;
            end
        end
    end

    // Pixel store: four copies, one per bilinear tap, all written together
    assign wr_en = adv && st_reg[ST_ADR].vld && (st_reg[ST_ADR].act == ACT_WRITE)
                && (32'(st_reg[ST_ADR].col) < MAX_COLS)
                && (32'(st_reg[ST_ADR].row) < MAX_ROWS);
    assign wr_addr = ADDR_W'(ADDR_W'(st_reg[ST_ADR].row) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(st_reg[ST_ADR].col));

    always_comb begin
        rd_addr[0] = ADDR_W'(ADDR_W'(st_reg[ST_ADR].y0) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(st_reg[ST_ADR].x0));
        rd_addr[1] = ADDR_W'(ADDR_W'(st_reg[ST_ADR].y0) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(st_reg[ST_ADR].x1));
        rd_addr[2] = ADDR_W'(ADDR_W'(st_reg[ST_ADR].y1) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(st_reg[ST_ADR].x0));
        rd_addr[3] = ADDR_W'(ADDR_W'(st_reg[ST_ADR].y1) * ADDR_W'(MAX_COLS)
                   + ADDR_W'(st_reg[ST_ADR].x1));
    end

    for (genvar m = 0; m < 4; m++) begin : g_bank
        logic [23:0] mem [STORE_DEPTH];

        always_ff @(posedge aclk) begin
            if (wr_en) begin
                mem[wr_addr] <= st_reg[ST_ADR].rgb;
            end
            if (adv) begin
                rd_reg[m] <= mem[rd_addr[m]];
            end
        end
    end

    // Mark the image loaded on the first in-range pixel write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= 1'b0;
        end else if (wr_en) begin
            loaded_reg <= 1'b1;
        end
    end

endmodule
